// ===== sv/sts_pkg.sv =====
package sts_pkg;

    // Fixed field widths
    localparam int PASS_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int COUNT_W    = 3;
    localparam int CHOSEN_W   = 2;

    // Default build parameters
    localparam int DEF_NUM_ENTRIES = 4;
    localparam int DEF_TICKET_BITS = 8;

    // Number of entries that own a ticket register
    localparam int TICKET_REGS = 4;

    // Reset value of the entry count register
    localparam int COUNT_RESET = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKETS_BASE = 3'd1;

    // Status from the stride unit to the scheduling core
    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] active;
    } t_stride_status;

endpackage

// ===== sv/stride_scheduler_top.sv =====
// Stride scheduler over up to NUM_ENTRIES entries.
// Channels (valid/ready, a word moves when both are high):
//   input  : i_in_valid / o_in_ready, field i_restart (one scheduling tick)
//   output : o_out_valid / i_out_ready, fields o_chosen_entry, o_pass_after,
//            o_cycle_done (one word per tick)
//   config : i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data; always ready.
//            Index 0 entry count, 1..4 ticket counts of entries 0..3.
// A tick accepted at a clock edge shows its result word in the cycle after.
// Throughput is one tick per cycle while the stride unit is idle and the
// receiver takes the words; the selection, the stride add and the equality
// check sit between the pass store and the result register.
// Strides are rebuilt by one multiplier per entry, one ticket per cycle, so
// after reset and after every register write o_in_ready stays low until
// the rebuild has stepped through all NUM_ENTRIES tickets.
// Reset clears all pass values, sets entry count 4 (capped at NUM_ENTRIES) and all tickets to 1.
// When the receiver stalls, the result word holds and a new tick is taken
// only in the cycle where the held word leaves.
module stride_scheduler_top import sts_pkg::*; #(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
    parameter int TICKET_BITS = DEF_TICKET_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_restart,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHOSEN_W-1:0]   o_chosen_entry,
    output logic [PASS_W-1:0]     o_pass_after,
    output logic                  o_cycle_done,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_stride_status                     status;
    logic [NUM_ENTRIES-1:0][PASS_W-1:0] stride;
    logic                               fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !status.busy && (!o_out_valid || i_out_ready);
    assign fire        = i_in_valid && o_in_ready;

    sts_stride_unit #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .TICKET_BITS (TICKET_BITS)
    ) u_stride (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_stride    (stride)
    );

    sts_sched_core #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_restart      (i_restart),
        .i_status       (status),
        .i_stride       (stride),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_chosen_entry (o_chosen_entry),
        .o_pass_after   (o_pass_after),
        .o_cycle_done   (o_cycle_done)
    );

endmodule

// ===== sv/sts_stride_unit.sv =====
module sts_stride_unit import sts_pkg::*; #(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
    parameter int TICKET_BITS = DEF_TICKET_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]                i_cfg_index,
    input  logic [CFG_DATA_W-1:0]               i_cfg_data,
    output t_stride_status                      o_status,
    output logic [NUM_ENTRIES-1:0][PASS_W-1:0]  o_stride
);

    localparam int TREG = (NUM_ENTRIES < TICKET_REGS) ? NUM_ENTRIES : TICKET_REGS;
    localparam int K_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int ACTIVE_RESET = (COUNT_RESET < NUM_ENTRIES) ? COUNT_RESET : NUM_ENTRIES;

    logic [TREG-1:0][TICKET_BITS-1:0]       r_tickets;
    logic [COUNT_W-1:0]                     r_active;
    logic [COUNT_W-1:0]                     n_active;
    logic                                   r_busy;
    logic [K_W-1:0]                         r_k;
    logic [NUM_ENTRIES-1:0][PASS_W-1:0]     r_acc;
    logic [NUM_ENTRIES-1:0][PASS_W-1:0]     n_acc;
    logic [NUM_ENTRIES-1:0][TICKET_BITS-1:0] tk_all;
    logic [TICKET_BITS-1:0]                 tk_sel;

    // Clamp a written entry count to 1..NUM_ENTRIES
    always_comb begin
        if (i_cfg_data[COUNT_W-1:0] == '0) begin
            n_active = COUNT_W'(1);
        end else if (i_cfg_data[COUNT_W-1:0] > COUNT_W'(NUM_ENTRIES)) begin
            n_active = COUNT_W'(NUM_ENTRIES);
        end else begin
            n_active = i_cfg_data[COUNT_W-1:0];
        end
    end

    // Ticket per entry; entries without a register count as one ticket
    always_comb begin
        for (int j = 0; j < NUM_ENTRIES; j++) begin
            if (j < TREG) begin
                tk_all[j] = r_tickets[j];
            end else begin
                tk_all[j] = TICKET_BITS'(1);
            end
        end
        tk_sel = tk_all[r_k];
    end

    // One multiply per lane per step: lane e skips its own ticket and inactive ones
    always_comb begin
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            if ((r_k == K_W'(e)) || (COUNT_W'(r_k) >= r_active)) begin
                n_acc[e] = r_acc[e];
            end else begin
                n_acc[e] = PASS_W'(r_acc[e] * tk_sel);
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= COUNT_W'(ACTIVE_RESET);
            for (int t = 0; t < TREG; t++) begin
                r_tickets[t] <= TICKET_BITS'(1);
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_ENTRY_COUNT) begin
                r_active <= n_active;
            end
            for (int t = 0; t < TREG; t++) begin
                if (i_cfg_index == REG_TICKETS_BASE + CFG_IDX_W'(t)) begin
                    r_tickets[t] <= TICKET_BITS'(i_cfg_data);
                end
            end
        end
    end

    // Stride sequencer: restarts after reset and after every register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_valid) begin
            r_busy <= 1'b1;
            r_k    <= '0;
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                r_acc[e] <= PASS_W'(1);
            end
        end else if (r_busy) begin
            r_acc <= n_acc;
            if (r_k == K_W'(NUM_ENTRIES - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_k <= r_k + K_W'(1);
            end
        end
    end

    assign o_status.busy   = r_busy;
    assign o_status.active = r_active;
    assign o_stride        = r_acc;

endmodule

// ===== sv/sts_sched_core.sv =====
module sts_sched_core import sts_pkg::*; #(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_fire,
    input  logic                               i_restart,
    input  t_stride_status                     i_status,
    input  logic [NUM_ENTRIES-1:0][PASS_W-1:0] i_stride,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [CHOSEN_W-1:0]                o_chosen_entry,
    output logic [PASS_W-1:0]                  o_pass_after,
    output logic                               o_cycle_done
);

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    logic [NUM_ENTRIES-1:0][PASS_W-1:0] r_pass;
    logic [NUM_ENTRIES-1:0][PASS_W-1:0] eff;
    logic [NUM_ENTRIES-1:0][PASS_W-1:0] upd;
    logic [IDX_W-1:0]                   run;
    logic [PASS_W-1:0]                  newpass;
    logic                               all_eq;
    logic                               r_out_valid;
    logic [IDX_W-1:0]                   r_chosen;
    logic [PASS_W-1:0]                  r_pass_after;
    logic                               r_done;

    // Restart clears passes before selection
    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            eff[i] = i_restart ? '0 : r_pass[i];
        end
    end

    // Smallest active pass, lowest index wins ties
    always_comb begin
        run = '0;
        for (int i = 1; i < NUM_ENTRIES; i++) begin
            if ((COUNT_W'(i) < i_status.active) && (eff[i] < eff[run])) begin
                run = IDX_W'(i);
            end
        end
    end

    // Advance the chosen pass and look for the end of a cycle
    always_comb begin
        newpass = eff[run] + i_stride[run];
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            upd[i] = (IDX_W'(i) == run) ? newpass : eff[i];
        end
        all_eq = 1'b1;
        for (int i = 1; i < NUM_ENTRIES; i++) begin
            if ((COUNT_W'(i) < i_status.active) && (upd[i] != upd[0])) begin
                all_eq = 1'b0;
            end
        end
    end

    // Pass store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= '0;
        end else if (i_fire) begin
            r_pass <= all_eq ? '0 : upd;
        end
    end

    // Result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_chosen     <= run;
            r_pass_after <= newpass;
            r_done       <= all_eq;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_chosen_entry = CHOSEN_W'(r_chosen);
    assign o_pass_after   = r_pass_after;
    assign o_cycle_done   = r_done;

endmodule

// ===== dv/stride_grant_checker.sv =====
`timescale 1ns / 100ps

// Watches the tick, result and register channels of the stride scheduler,
// keeps its own copy of the pass values and tickets, and compares every
// result word with the grant it predicts.
module stride_grant_checker import sts_pkg::*; #(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
    parameter int TICKET_BITS = DEF_TICKET_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_restart,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [CHOSEN_W-1:0]   i_chosen_entry,
    input  logic [PASS_W-1:0]     i_pass_after,
    input  logic                  i_cycle_done,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int unsigned TICKET_MASK =
        (TICKET_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TICKET_BITS) - 32'd1);

    typedef struct packed {
        logic [CHOSEN_W-1:0] chosen;
        logic [PASS_W-1:0]   pass_after;
        logic                done;
    } grant_t;

    // Mirror of the scheduler state
    int unsigned       count_mirror;
    int unsigned       ticket_mirror [NUM_ENTRIES];
    logic [PASS_W-1:0] pass_mirror   [NUM_ENTRIES];

    // Grants predicted but not yet seen on the result channel
    grant_t grant_q [$];

    function automatic void clear_passes();
        for (int i = 0; i < NUM_ENTRIES; i++) pass_mirror[i] = '0;
    endfunction

    // One scheduling tick: pick the lowest pass, add the stride, check for
    // the end of a cycle.
    function automatic grant_t predict_grant(input logic restart);
        int unsigned       act;
        int unsigned       pick;
        logic [63:0]       stride;
        logic [PASS_W-1:0] sum;
        logic              level;
        grant_t            g;
        act = (count_mirror == 0) ? 1 :
              (count_mirror > NUM_ENTRIES) ? NUM_ENTRIES : count_mirror;
        if (restart) clear_passes();
        pick = 0;
        for (int i = 1; i < act; i++) begin
            if (pass_mirror[i] < pass_mirror[pick]) pick = i;
        end
        // stride is the product of the other active tickets
        stride = 64'd1;
        for (int i = 0; i < act; i++) begin
            if (i != pick) stride = stride * 64'(ticket_mirror[i]);
        end
        sum = pass_mirror[pick] + stride[PASS_W-1:0];
        pass_mirror[pick] = sum;
        level = 1'b1;
        for (int i = 1; i < act; i++) begin
            if (pass_mirror[i] != pass_mirror[0]) level = 1'b0;
        end
        g.chosen     = CHOSEN_W'(pick);
        g.pass_after = sum;
        g.done       = level;
        if (level) clear_passes();
        return g;
    endfunction

    always @(posedge i_clk) begin
        grant_t want;
        if (!i_rst_n) begin
            count_mirror = COUNT_RESET;
            for (int i = 0; i < NUM_ENTRIES; i++) ticket_mirror[i] = 1;
            clear_passes();
            grant_q.delete();
            o_errors = 0;
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_ENTRY_COUNT) begin
                    count_mirror = i_cfg_data[COUNT_W-1:0];
                end else if (i_cfg_index >= REG_TICKETS_BASE &&
                             i_cfg_index < REG_TICKETS_BASE + TICKET_REGS &&
                             i_cfg_index - REG_TICKETS_BASE < NUM_ENTRIES) begin
                    ticket_mirror[i_cfg_index - REG_TICKETS_BASE] =
                        i_cfg_data & TICKET_MASK;
                end
            end

            // result word against the oldest grant
            if (i_out_valid && i_out_ready) begin
                if (grant_q.size() == 0) begin
                    $error("result word with no tick pending");
                    o_errors++;
                end else begin
                    want = grant_q.pop_front();
                    if (i_chosen_entry !== want.chosen) begin
                        $error("chosen_entry: expected %0d, got %0d",
                               want.chosen, i_chosen_entry);
                        o_errors++;
                    end
                    if (i_pass_after !== want.pass_after) begin
                        $error("pass_after: expected %0d, got %0d",
                               want.pass_after, i_pass_after);
                        o_errors++;
                    end
                    if (i_cycle_done !== want.done) begin
                        $error("cycle_done: expected %0d, got %0d",
                               want.done, i_cycle_done);
                        o_errors++;
                    end
                end
            end

            // accepted tick
            if (i_in_valid && i_in_ready) grant_q.push_back(predict_grant(i_restart));
        end
        o_pending = grant_q.size();
    end

endmodule

// ===== dv/tb_stride_scheduler_top.sv =====
`timescale 1ns / 100ps

module tb_stride_scheduler_top;
    import sts_pkg::*;

    localparam int NUM_ENTRIES  = DEF_NUM_ENTRIES;
    localparam int TICKET_BITS  = DEF_TICKET_BITS;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_TICKS = 1000;
    localparam int HOLD_AFTER   = 300;   // words seen before the long stall
    localparam int HOLD_CYCLES  = 400;
    localparam int WRAP_TICKS   = 999;   // stops short of the full cycle
    localparam logic [CFG_DATA_W-1:0] TICKET_MAX = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_restart;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [CHOSEN_W-1:0]   o_chosen_entry;
    logic [PASS_W-1:0]     o_pass_after;
    logic                  o_cycle_done;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int ticks_in_flight;
    int words_out   = 0;
    int cycle_count = 0;

    stride_scheduler_top #(
        .NUM_ENTRIES(NUM_ENTRIES),
        .TICKET_BITS(TICKET_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_restart(i_restart),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_chosen_entry(o_chosen_entry),
        .o_pass_after(o_pass_after),
        .o_cycle_done(o_cycle_done),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    stride_grant_checker #(
        .NUM_ENTRIES(NUM_ENTRIES),
        .TICKET_BITS(TICKET_BITS)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_ready(o_in_ready),
        .i_restart(i_restart),
        .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_chosen_entry(o_chosen_entry),
        .i_pass_after(o_pass_after),
        .i_cycle_done(o_cycle_done),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_errors(fail_count),
        .o_pending(ticks_in_flight)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) words_out <= words_out + 1;
    end

    // Gap length: mostly none or short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Tickets lean small so cycles complete, with extremes and zero mixed in
    function automatic logic [CFG_DATA_W-1:0] pick_ticket();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return CFG_DATA_W'($urandom_range(1, 6));
        if (r < 65) return CFG_DATA_W'($urandom_range(250, 255));
        if (r < 72) return '0;
        return CFG_DATA_W'($urandom_range(0, 255));
    endfunction

    // Returns at a rising edge once every predicted grant has come back
    task automatic wait_drained();
        do @(negedge i_clk); while (ticks_in_flight != 0);
        @(posedge i_clk);
    endtask

    // Leaves valid high so writes can go back to back
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic poke_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_write(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] cnt,
                              input logic [CFG_DATA_W-1:0] t0, t1, t2, t3);
        wait_drained();
        cfg_write(REG_ENTRY_COUNT, cnt);
        cfg_write(REG_TICKETS_BASE, t0);
        cfg_write(CFG_IDX_W'(REG_TICKETS_BASE + 1), t1);
        cfg_write(CFG_IDX_W'(REG_TICKETS_BASE + 2), t2);
        cfg_write(CFG_IDX_W'(REG_TICKETS_BASE + 3), t3);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer n ticks; valid stays up across zero gaps
    task automatic run_ticks(input int n, input int restart_pct);
        bit steady;
        int gap;
        steady = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++) begin
            i_in_valid <= 1'b1;
            i_restart  <= ($urandom_range(0, 99) < restart_pct);
            do @(posedge i_clk); while (!o_in_ready);
            gap = steady ? 0 : idle_len();
            if (k == n - 1 && gap == 0) gap = 1;
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stalls, one long hold once HOLD_AFTER words have been seen
    initial begin
        bit held;
        held = 1'b0;
        i_out_ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && words_out >= HOLD_AFTER) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end else if ($urandom_range(0, 2) != 0) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat (1 + idle_len()) @(posedge i_clk);
            end
        end
    end

    // Tick and register stimulus
    initial begin
        int rand_ticks;
        int n;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_restart   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: four entries, one ticket each, then a restart
        run_ticks(5, 0);
        run_ticks(1, 100);
        // single entry completes a cycle on every tick
        set_config(8'd1, TICKET_MAX, TICKET_MAX, TICKET_MAX, TICKET_MAX);
        run_ticks(2, 0);
        // count of zero acts as one
        set_config(8'd0, TICKET_MAX, TICKET_MAX, TICKET_MAX, TICKET_MAX);
        run_ticks(1, 0);
        // count above the entry number saturates, largest strides
        set_config(8'd7, TICKET_MAX, TICKET_MAX, TICKET_MAX, TICKET_MAX);
        run_ticks(5, 0);
        // zero ticket, upper count bits set
        set_config(8'hFA, 8'd0, 8'd7, 8'd1, 8'd1);
        run_ticks(3, 0);
        set_config(8'd2, 8'd0, 8'd0, 8'd1, 8'd1);
        run_ticks(1, 0);
        // lower the count mid cycle, then raise it so stale passes rejoin
        set_config(8'd4, 8'd3, 8'd5, 8'd1, 8'd2);
        run_ticks(2, 0);
        set_config(8'd2, 8'd3, 8'd5, 8'd1, 8'd2);
        run_ticks(2, 0);
        set_config(8'd4, 8'd3, 8'd5, 8'd1, 8'd2);
        run_ticks(2, 0);
        // writes to unused indexes change nothing
        for (int idx = REG_TICKETS_BASE + TICKET_REGS; idx < 2 ** CFG_IDX_W; idx++)
            poke_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        run_ticks(1, 0);

        // Passes climb near the product of all tickets; switching the last
        // ticket makes equal passes unreachable, so they wrap past 2^32.
        set_config(8'd4, TICKET_MAX, TICKET_MAX, TICKET_MAX, TICKET_MAX - 8'd1);
        run_ticks(1, 100);
        run_ticks(WRAP_TICKS, 0);
        poke_reg(CFG_IDX_W'(REG_TICKETS_BASE + 3), TICKET_MAX);
        run_ticks(60, 0);

        // random settings and tick bursts
        rand_ticks = 0;
        while (rand_ticks < RANDOM_TICKS) begin
            if ($urandom_range(0, 3) == 0)
                poke_reg(CFG_IDX_W'($urandom), CFG_DATA_W'($urandom));
            else
                set_config(($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom) :
                               CFG_DATA_W'($urandom_range(1, NUM_ENTRIES)),
                           pick_ticket(), pick_ticket(), pick_ticket(), pick_ticket());
            n = $urandom_range(3, 60);
            run_ticks(n, 4);
            rand_ticks += n;
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
